// ===== src/csd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the crossfed saturating stereo delay.
// Used by the channel interfaces, the lane, the top level and the checker.

package csd_pkg;

	// Field widths
	localparam int unsigned SAMPLE_W   = 24;
	localparam int unsigned LINE_W     = 23;
	localparam int unsigned DELAY_W    = 17;
	localparam int unsigned FB_W       = 16;
	localparam int unsigned DRIVE_W    = 16;
	localparam int unsigned NORM_W     = 15;
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 32;

	// Datapath widths
	localparam int unsigned MAG_W      = 24;   // |input + crossfeed|
	localparam int unsigned MAG_X_W    = 40;   // magnitude times drive, Q.33
	localparam int unsigned TANH_W     = 31;   // table entry, Q1.30 up to 1.0
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned POS_FRAC_LSB = 20;
	localparam int unsigned POS_INT_LSB  = 36;

	// Register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_DELAY_LENGTH  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_GAIN    = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_NORM    = 8'd3;

	// Register reset values
	localparam logic [DELAY_W-1:0] DELAY_LENGTH_RST  = 17'd21168;
	localparam logic [FB_W-1:0]    FEEDBACK_GAIN_RST = 16'd20972;
	localparam logic [DRIVE_W-1:0] DRIVE_GAIN_RST    = 16'd8028;
	localparam logic [NORM_W-1:0]  DRIVE_NORM_RST    = 15'd17046;

	// Limits applied to register values
	localparam logic [FB_W-1:0]    FB_MAX    = 16'd62259;
	localparam logic [DRIVE_W-1:0] DRIVE_MIN = 16'd4096;
	localparam logic [DRIVE_W-1:0] DRIVE_MAX = 16'd36864;

	// Arithmetic constants
	localparam logic signed [18:0]     CROSS_COEF = 19'sd188744;  // 0.18 in Q0.20
	localparam logic signed [LINE_W-1:0] LIMIT_POS = 23'sd3145728; // +1.5 in Q2.21
	localparam logic signed [LINE_W-1:0] LIMIT_NEG = -23'sd3145728;
	localparam logic [TANH_W-1:0]      TANH_ONE   = 31'h4000_0000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [LINE_W-1:0]   line_t;

	// Clamped gains handed to each lane
	typedef struct packed {
		logic [FB_W-1:0]    fb_gain;
		logic [DRIVE_W-1:0] drive;
		logic [NORM_W-1:0]  norm;
	} lane_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_START,
		ST_CALC,
		ST_MERGE
	} state_t;

endpackage

// ===== src/csd_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the crossfed saturating stereo delay: input frames,
// result frames and configuration writes. Depends on csd_pkg.

interface csd_in_if;
	logic              valid;
	logic              ready;
	csd_pkg::sample_t  sample_left;
	csd_pkg::sample_t  sample_right;

	modport source (output valid, output sample_left, output sample_right, input ready);
	modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

interface csd_out_if;
	logic            valid;
	logic            ready;
	csd_pkg::line_t  delayed_left;
	csd_pkg::line_t  delayed_right;

	modport source (output valid, output delayed_left, output delayed_right, input ready);
	modport sink (input valid, input delayed_left, input delayed_right, output ready);
endinterface

interface csd_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [csd_pkg::CFG_INDEX_W-1:0]     index;
	logic [csd_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/csd_line.sv =====
`timescale 1ns / 1ps
// One delay line: a single-port-write, registered-read sample memory.
// Stand-alone; no package items needed beyond plain logic.

module csd_line #(
	parameter int unsigned DEPTH = 131072,
	parameter int unsigned WIDTH = 23
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// Write the new sample at the write pointer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Register the delayed sample every cycle
	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ===== src/csd_lane.sv =====
`timescale 1ns / 1ps
// One channel lane: crossfeed, drive, interpolated tanh table, norm, feedback and clamp.
// Nine pipeline stages; depends on csd_pkg. The tanh table is a ROM built at elaboration.

module csd_lane #(
	parameter int unsigned TANH_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  csd_pkg::lane_cfg_t cfg,
	input  csd_pkg::sample_t   sample,
	input  csd_pkg::line_t     d_own,
	input  csd_pkg::line_t     d_oth,
	output logic               done,
	output csd_pkg::line_t     result
);

	localparam int unsigned AW = $clog2(TANH_DEPTH);
	localparam int unsigned PW = csd_pkg::MAG_X_W + $clog2(TANH_DEPTH + 1);
	localparam int unsigned IW = PW - csd_pkg::POS_INT_LSB;
	localparam int unsigned TW = csd_pkg::TANH_W;
	localparam int unsigned STAGES = 9;

	typedef logic [2*TW-1:0] rom_word_t;
	typedef rom_word_t rom_array_t [TANH_DEPTH];

	// Shift-subtract division for the table build
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = {rem[63:0], num[k]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[k] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Entry i holds tanh at i and i+1 steps, so one read serves the interpolation
	function automatic rom_array_t build_rom();
		rom_array_t  rom;
		logic [63:0] one;
		logic [63:0] h;
		logic [63:0] h2;
		logic [63:0] p;
		logic [63:0] th;
		logic [63:0] t;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] nv;
		one = 64'd1 << 30;
		h   = (64'd8 << 30) / TANH_DEPTH;
		h2  = (h * h) >> 30;
		p   = h;
		th  = h;
		p   = (p * h2) >> 30;
		th  = th - p / 64'd3;
		p   = (p * h2) >> 30;
		th  = th + (64'd2 * p) / 64'd15;
		p   = (p * h2) >> 30;
		th  = th - (64'd17 * p) / 64'd315;
		p   = (p * h2) >> 30;
		th  = th + (64'd62 * p) / 64'd2835;
		if (th > one) begin
			th = one;
		end
		t = '0;
		for (int i = 0; i < TANH_DEPTH; i++) begin
			num = (t + th) << 30;
			den = one + ((t * th) >> 30);
			nv  = udiv64(num, den);
			if (nv > one) begin
				nv = one;
			end
			rom[i] = {nv[TW-1:0], t[TW-1:0]};
			t = nv;
		end
		return rom;
	endfunction

	localparam rom_array_t TANH_ROM = build_rom();

	// Stage valids
	logic [STAGES-1:0] vld_q;

	// Stage 1: products
	logic signed [41:0]              cross_prod_s1;
	logic signed [38:0]              fb_prod_s1;
	csd_pkg::sample_t                in_s1;
	// Stage 2: input plus crossfeed, rounded feedback
	logic signed [24:0]              sum_s2;
	csd_pkg::line_t                  fb_s2;
	// Stage 3: driven magnitude
	logic [csd_pkg::MAG_X_W-1:0]     x_s3;
	logic                            neg_s3;
	csd_pkg::line_t                  fb_s3;
	// Stage 4: table position
	logic [PW-1:0]                   pos_s4;
	logic                            neg_s4;
	csd_pkg::line_t                  fb_s4;
	// Stage 5: table read
	rom_word_t                       rom_s5;
	logic [csd_pkg::FRAC_W-1:0]      frac_s5;
	logic                            sat_s5;
	logic                            neg_s5;
	csd_pkg::line_t                  fb_s5;
	// Stage 6: interpolation product
	logic [TW+csd_pkg::FRAC_W-1:0]   interp_s6;
	logic [TW-1:0]                   base_s6;
	logic                            sat_s6;
	logic                            neg_s6;
	csd_pkg::line_t                  fb_s6;
	// Stage 7: tanh value
	logic [TW-1:0]                   t_s7;
	logic                            neg_s7;
	csd_pkg::line_t                  fb_s7;
	// Stage 8: normalized product
	logic [TW+csd_pkg::NORM_W-1:0]   scaled_s8;
	logic                            neg_s8;
	csd_pkg::line_t                  fb_s8;
	// Stage 9: result
	csd_pkg::line_t                  result_s9;

	// Combinational helpers
	logic signed [41:0]              cross_sum;
	logic signed [21:0]              cross_rnd;
	logic signed [38:0]              fb_sum;
	logic [csd_pkg::MAG_W-1:0]       mag;
	logic                            sat_c;
	logic [AW-1:0]                   rom_addr;
	logic [TW-1:0]                   diff;
	logic [TW+csd_pkg::NORM_W-1:0]   scaled_rnd;
	logic [csd_pkg::LINE_W-1:0]      drv_mag;
	logic signed [23:0]              drv_signed;
	logic signed [24:0]              total;

	// Round crossfeed and feedback half toward plus infinity
	assign cross_sum = cross_prod_s1 + 42'sd524288;
	assign cross_rnd = $signed(cross_sum[41:20]);
	assign fb_sum    = fb_prod_s1 + 39'sd32768;

	// Magnitude of the saturator input
	assign mag = sum_s2[24] ? csd_pkg::MAG_W'(-sum_s2) : csd_pkg::MAG_W'(sum_s2);

	// Past the table span the value is exactly one
	assign sat_c    = pos_s4[PW-1:csd_pkg::POS_INT_LSB] >= IW'(TANH_DEPTH);
	assign rom_addr = sat_c ? '0 : pos_s4[csd_pkg::POS_INT_LSB +: AW];

	assign diff = rom_s5[2*TW-1:TW] - rom_s5[TW-1:0];

	// Scale back to Q2.21, restore sign, add feedback
	assign scaled_rnd = scaled_s8 + (TW+csd_pkg::NORM_W)'(23'h40_0000);
	assign drv_mag    = scaled_rnd[TW+csd_pkg::NORM_W-1:23];
	assign drv_signed = neg_s8 ? -$signed({1'b0, drv_mag}) : $signed({1'b0, drv_mag});
	assign total      = 25'(drv_signed) + 25'(fb_s8);

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[STAGES-2:0], start};
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (start) begin
			cross_prod_s1 <= d_oth * csd_pkg::CROSS_COEF;
			fb_prod_s1    <= d_own * $signed({1'b0, cfg.fb_gain});
			in_s1         <= sample;
		end

		sum_s2 <= 25'(in_s1) + 25'(cross_rnd);
		fb_s2  <= $signed(fb_sum[38:16]);

		x_s3   <= csd_pkg::MAG_X_W'(mag) * csd_pkg::MAG_X_W'(cfg.drive);
		neg_s3 <= sum_s2[24];
		fb_s3  <= fb_s2;

		pos_s4 <= PW'(x_s3) * PW'(TANH_DEPTH);
		neg_s4 <= neg_s3;
		fb_s4  <= fb_s3;

		rom_s5  <= TANH_ROM[rom_addr];
		frac_s5 <= pos_s4[csd_pkg::POS_INT_LSB-1:csd_pkg::POS_FRAC_LSB];
		sat_s5  <= sat_c;
		neg_s5  <= neg_s4;
		fb_s5   <= fb_s4;

		interp_s6 <= (TW+csd_pkg::FRAC_W)'(diff) * (TW+csd_pkg::FRAC_W)'(frac_s5);
		base_s6   <= rom_s5[TW-1:0];
		sat_s6    <= sat_s5;
		neg_s6    <= neg_s5;
		fb_s6     <= fb_s5;

		t_s7   <= sat_s6 ? csd_pkg::TANH_ONE
			: base_s6 + interp_s6[TW+csd_pkg::FRAC_W-1:csd_pkg::FRAC_W];
		neg_s7 <= neg_s6;
		fb_s7  <= fb_s6;

		scaled_s8 <= (TW+csd_pkg::NORM_W)'(t_s7) * (TW+csd_pkg::NORM_W)'(cfg.norm);
		neg_s8    <= neg_s7;
		fb_s8     <= fb_s7;

		// Clamp to plus or minus 1.5
		if (total > 25'(csd_pkg::LIMIT_POS)) begin
			result_s9 <= csd_pkg::LIMIT_POS;
		end else if (total < 25'(csd_pkg::LIMIT_NEG)) begin
			result_s9 <= csd_pkg::LIMIT_NEG;
		end else begin
			result_s9 <= csd_pkg::LINE_W'(total);
		end
	end

	assign done   = vld_q[STAGES-1];
	assign result = result_s9;

endmodule

// ===== src/crossfed_saturating_stereo_delay_unit.sv =====
`timescale 1ns / 1ps
// Crossfed saturating stereo delay, top level. Depends on csd_pkg, csd_if, csd_line, csd_lane.
// The result request becomes valid once the merge step writes both lines back and latches
// the delayed samples. Frames pass through the line read, the nine-stage lane pipeline and
// the merge step; a new frame is taken only after the merge, which waits while the output stalls.
// Reset: arst_n clears control and loads register defaults; unwritten line entries read
// as zero through a fill mark, so frames are taken right after reset.

module crossfed_saturating_stereo_delay_unit #(
	parameter int unsigned LINE_DEPTH       = 131072,
	parameter int unsigned TANH_TABLE_DEPTH = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	csd_in_if.sink     frame_in,
	csd_out_if.source  frame_out,
	csd_cfg_if.sink    cfg
);

	localparam int unsigned AW = $clog2(LINE_DEPTH);
	localparam int unsigned DW = ((AW > csd_pkg::DELAY_W) ? AW : csd_pkg::DELAY_W) + 1;
	localparam logic [DW-1:0] DIST_MAX  = DW'(LINE_DEPTH - 1);
	localparam logic [AW-1:0] PTR_LAST  = AW'(LINE_DEPTH - 1);
	localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(LINE_DEPTH);

	// Configuration registers
	logic [csd_pkg::DELAY_W-1:0] delay_length_q;
	logic [csd_pkg::FB_W-1:0]    feedback_gain_q;
	logic [csd_pkg::DRIVE_W-1:0] drive_gain_q;
	logic [csd_pkg::NORM_W-1:0]  drive_norm_q;

	// Control
	csd_pkg::state_t state_q;
	csd_pkg::state_t state_nxt;
	logic [AW-1:0]   wp_q;
	logic            wrapped_q;
	logic [AW-1:0]   rp_q;
	logic            rd_valid_q;
	logic            out_valid_q;

	// Payload
	csd_pkg::sample_t sample_left_q;
	csd_pkg::sample_t sample_right_q;
	csd_pkg::line_t   out_left_q;
	csd_pkg::line_t   out_right_q;

	// Combinational
	logic               in_fire;
	logic               lane_start;
	logic               out_free;
	logic               merge_fire;
	logic [DW-1:0]      dist_ext;
	logic [DW-1:0]      dist_clamped;
	logic [AW:0]        dist_x;
	logic [AW:0]        wp_ext;
	logic [AW:0]        rp_ext;
	logic [AW-1:0]      rp_next;
	logic [csd_pkg::LINE_W-1:0] rd_left;
	logic [csd_pkg::LINE_W-1:0] rd_right;
	csd_pkg::line_t     dl;
	csd_pkg::line_t     dr;
	csd_pkg::lane_cfg_t lane_cfg;
	logic               done_l;
	logic               done_r;
	csd_pkg::line_t     res_l;
	csd_pkg::line_t     res_r;

	assign cfg.ready = 1'b1;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q  <= csd_pkg::DELAY_LENGTH_RST;
			feedback_gain_q <= csd_pkg::FEEDBACK_GAIN_RST;
			drive_gain_q    <= csd_pkg::DRIVE_GAIN_RST;
			drive_norm_q    <= csd_pkg::DRIVE_NORM_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				csd_pkg::REG_DELAY_LENGTH: begin
					delay_length_q <= cfg.data[csd_pkg::DELAY_W-1:0];
				end
				csd_pkg::REG_FEEDBACK_GAIN: begin
					feedback_gain_q <= cfg.data[csd_pkg::FB_W-1:0];
				end
				csd_pkg::REG_DRIVE_GAIN: begin
					drive_gain_q <= cfg.data[csd_pkg::DRIVE_W-1:0];
				end
				csd_pkg::REG_DRIVE_NORM: begin
					drive_norm_q <= cfg.data[csd_pkg::NORM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp feedback and drive gains for the lanes; the norm passes through
	always_comb begin
		lane_cfg.fb_gain = (feedback_gain_q > csd_pkg::FB_MAX) ? csd_pkg::FB_MAX
			: feedback_gain_q;
		if (drive_gain_q < csd_pkg::DRIVE_MIN) begin
			lane_cfg.drive = csd_pkg::DRIVE_MIN;
		end else if (drive_gain_q > csd_pkg::DRIVE_MAX) begin
			lane_cfg.drive = csd_pkg::DRIVE_MAX;
		end else begin
			lane_cfg.drive = drive_gain_q;
		end
		lane_cfg.norm = drive_norm_q;
	end

	// Read pointer: clamp the distance, step back from the write pointer with wrap
	always_comb begin
		dist_ext = DW'(delay_length_q);
		if (dist_ext == '0) begin
			dist_clamped = DW'(1);
		end else if (dist_ext > DIST_MAX) begin
			dist_clamped = DIST_MAX;
		end else begin
			dist_clamped = dist_ext;
		end
		dist_x = (AW+1)'(dist_clamped);
		wp_ext = {1'b0, wp_q};
		if (wp_ext >= dist_x) begin
			rp_ext = wp_ext - dist_x;
		end else begin
			rp_ext = wp_ext + DEPTH_EXT - dist_x;
		end
	end

	assign rp_next = rp_ext[AW-1:0];

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			csd_pkg::ST_IDLE: begin
				if (frame_in.valid) begin
					state_nxt = csd_pkg::ST_READ;
				end
			end
			csd_pkg::ST_READ: begin
				state_nxt = csd_pkg::ST_START;
			end
			csd_pkg::ST_START: begin
				state_nxt = csd_pkg::ST_CALC;
			end
			csd_pkg::ST_CALC: begin
				if (done_l && done_r) begin
					state_nxt = csd_pkg::ST_MERGE;
				end
			end
			csd_pkg::ST_MERGE: begin
				if (out_free) begin
					state_nxt = csd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = csd_pkg::ST_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		frame_in.ready = 1'b0;
		lane_start     = 1'b0;
		merge_fire     = 1'b0;
		case (state_q)
			csd_pkg::ST_IDLE: begin
				frame_in.ready = 1'b1;
			end
			csd_pkg::ST_START: begin
				lane_start = 1'b1;
			end
			csd_pkg::ST_MERGE: begin
				merge_fire = out_free;
			end
			default: begin
			end
		endcase
	end

	assign in_fire  = frame_in.valid && frame_in.ready;
	assign out_free = !out_valid_q || frame_out.ready;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csd_pkg::ST_IDLE;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			rd_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_fire) begin
				rd_valid_q <= wrapped_q || (rp_next < wp_q);
			end
			// Advance the write pointer and mark the line full on wrap
			if (merge_fire) begin
				if (wp_q == PTR_LAST) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + AW'(1);
				end
			end
			if (merge_fire) begin
				out_valid_q <= 1'b1;
			end else if (frame_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the accepted request and the result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_left_q  <= frame_in.sample_left;
			sample_right_q <= frame_in.sample_right;
			rp_q           <= rp_next;
		end
		if (merge_fire) begin
			out_left_q  <= dl;
			out_right_q <= dr;
		end
	end

	// Delay lines
	csd_line #(
		.DEPTH (LINE_DEPTH),
		.WIDTH (csd_pkg::LINE_W)
	) u_line_left (
		.clk     (clk),
		.wr_en   (merge_fire),
		.wr_addr (wp_q),
		.wr_data (res_l),
		.rd_addr (rp_q),
		.rd_data (rd_left)
	);

	csd_line #(
		.DEPTH (LINE_DEPTH),
		.WIDTH (csd_pkg::LINE_W)
	) u_line_right (
		.clk     (clk),
		.wr_en   (merge_fire),
		.wr_addr (wp_q),
		.wr_data (res_r),
		.rd_addr (rp_q),
		.rd_data (rd_right)
	);

	// Entries not yet written read as zero
	assign dl = rd_valid_q ? $signed(rd_left) : '0;
	assign dr = rd_valid_q ? $signed(rd_right) : '0;

	// Lanes, each fed the other channel's delayed sample
	csd_lane #(
		.TANH_DEPTH (TANH_TABLE_DEPTH)
	) u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.cfg    (lane_cfg),
		.sample (sample_left_q),
		.d_own  (dl),
		.d_oth  (dr),
		.done   (done_l),
		.result (res_l)
	);

	csd_lane #(
		.TANH_DEPTH (TANH_TABLE_DEPTH)
	) u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.cfg    (lane_cfg),
		.sample (sample_right_q),
		.d_own  (dr),
		.d_oth  (dl),
		.done   (done_r),
		.result (res_r)
	);

	assign frame_out.valid         = out_valid_q;
	assign frame_out.delayed_left  = out_left_q;
	assign frame_out.delayed_right = out_right_q;

endmodule

// ===== src/csd_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the crossfed saturating stereo delay, bound to the top level.
// Depends on csd_pkg and crossfed_saturating_stereo_delay_unit.

module csd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input csd_pkg::line_t delayed_left,
	input csd_pkg::line_t delayed_right
);

	// Hold a stalled result request
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(delayed_left) && $stable(delayed_right))
		else $error("result payload changed while stalled");

	// Delayed samples stay inside the clamp range
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (delayed_left <= csd_pkg::LIMIT_POS)
			&& (delayed_left >= csd_pkg::LIMIT_NEG)
			&& (delayed_right <= csd_pkg::LIMIT_POS)
			&& (delayed_right >= csd_pkg::LIMIT_NEG))
		else $error("delayed sample outside clamp range");

	// One frame at a time: drop ready right after an accept
	a_in_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on back-to-back cycles");

endmodule

bind crossfed_saturating_stereo_delay_unit csd_checker u_csd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (frame_in.valid),
	.in_ready      (frame_in.ready),
	.out_valid     (frame_out.valid),
	.out_ready     (frame_out.ready),
	.delayed_left  (frame_out.delayed_left),
	.delayed_right (frame_out.delayed_right)
);
